### rtl/core/bagsel_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the best alignment group selector.
// Depends on nothing; used by the top level of the block.
package bagsel_pkg;

    // One alignment record as it arrives on the input channel.
    typedef struct packed {
        logic [6:0]  percent_identity;
        logic [23:0] match_count;
        logic [9:0]  exon_count;
        logic        last_in_group;
    } in_item_t;

    // One per-record result of a judged group.
    typedef struct packed {
        logic [5:0] record_index;
        logic       selected;
        logic [3:0] decision_case;
        logic       group_overflow;
        logic       last_result;
    } out_item_t;

    // A record as held in the group store.
    typedef struct packed {
        logic [6:0]  id;
        logic [23:0] nm;
        logic [9:0]  ex;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    localparam logic [7:0] MARGIN_RESET = 8'd10;
    localparam logic [7:0] IDENT_SLACK  = 8'd3;

    // Decision codes reported with every result of a group.
    localparam logic [3:0] DC_SINGLE       = 4'd0;
    localparam logic [3:0] DC_AGREE_BEST   = 4'd1;
    localparam logic [3:0] DC_AGREE_EXONS  = 4'd2;
    localparam logic [3:0] DC_IDENT_BEST   = 4'd3;
    localparam logic [3:0] DC_IDENT_EXONS  = 4'd4;
    localparam logic [3:0] DC_ALPHA        = 4'd5;
    localparam logic [3:0] DC_MORE_EXONS   = 4'd6;
    localparam logic [3:0] DC_IDENT_GAP    = 4'd7;
    localparam logic [3:0] DC_RUNNER_UP    = 4'd8;
    localparam logic [3:0] DC_RUNNER_EXONS = 4'd9;

endpackage

### rtl/core/bagsel_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bagsel_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/best_alignment_group_selector_unit.sv
`timescale 1ns / 1ps
// Top level of the best alignment group selector: group store, sequencer, alpha test.
// Depends on bagsel_pkg and bagsel_ram.

// Records of a group are taken one per cycle while the block is idle and written
// into the group store; running bests are kept as they arrive. The record marked
// last_in_group closes the group, and the block then stalls its input until the
// last result of the group has been loaded for output. Judging walks the store
// with its single read port, one record per cycle, in up to three passes (ranking,
// exon search, margin pick), with an alpha test on one shared 32x8 multiplier
// between them. Results then leave one at a time, each read from the store before
// it is loaded, and wait while the output is stalled. Records beyond MAX_GROUP are
// dropped and the group's results are flagged with group_overflow.
module best_alignment_group_selector_unit #(
    parameter int MAX_GROUP = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata,
    input  logic                  rec_valid,
    output logic                  rec_stall,
    input  bagsel_pkg::in_item_t  rec_data,
    output logic                  res_valid,
    input  logic                  res_stall,
    output bagsel_pkg::out_item_t res_data
);

    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CW = $clog2(MAX_GROUP + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_ALPHA   = 3'd2;
    localparam logic [2:0] S_EMIT_RD = 3'd3;
    localparam logic [2:0] S_EMIT_LD = 3'd4;

    localparam logic [3:0] PH_EQ_MAX = 4'd0;
    localparam logic [3:0] PH_EQ_MG  = 4'd1;
    localparam logic [3:0] PH_RANK   = 4'd2;
    localparam logic [3:0] PH_R_MAX  = 4'd3;
    localparam logic [3:0] PH_R_MG   = 4'd4;
    localparam logic [3:0] PH_A_MAX  = 4'd5;
    localparam logic [3:0] PH_EXX    = 4'd6;
    localparam logic [3:0] PH_M_MG   = 4'd7;

    typedef struct packed {
        logic [3:0]  phase;
        logic [2:0]  step;
        logic [6:0]  q_id;
        logic [23:0] q_nm;
        logic [9:0]  acc_ex;
        logic [23:0] acc_nm;
        logic [6:0]  idi;
        logic [23:0] nmi;
        logic [6:0]  idm;
        logic [23:0] nmm;
        logic [9:0]  exi;
        logic [9:0]  exm;
        logic [39:0] prod;
        logic [32:0] dval;
        logic [6:0]  sid;
        logic [23:0] snm;
        logic [9:0]  sex;
        logic [3:0]  dcase;
        logic        sel_all;
    } ctx_t;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        addr_reg, addr_next;
    logic                 vld_reg, vld_next;
    logic [6:0]           ifi_id_reg, ifi_id_next;
    logic [23:0]          ifi_nm_reg, ifi_nm_next;
    logic [6:0]           mfi_id_reg, mfi_id_next;
    logic [23:0]          mfi_nm_reg, mfi_nm_next;
    logic                 ovf_reg, ovf_next;
    logic [7:0]           margin_reg, margin_next;
    logic                 res_valid_reg, res_valid_next;
    bagsel_pkg::out_item_t res_data_reg, res_data_next;
    ctx_t                 ctx_reg, ctx_next;

    logic                 take;
    logic                 ram_we;
    logic                 ram_re;
    bagsel_pkg::rec_t     wr_rec;
    bagsel_pkg::rec_t     rd_rec;
    logic [31:0]          mul_a;
    logic [7:0]           mul_b;
    logic [39:0]          mul_p;
    logic [40:0]          d_ext;
    logic [40:0]          d80;
    logic                 alpha_lt;
    logic                 mg_ok;
    logic                 ex_ok;

    assign take      = rec_valid && (state_reg == S_IDLE);
    assign rec_stall = (state_reg != S_IDLE);
    assign wr_rec    = '{id: rec_data.percent_identity, nm: rec_data.match_count,
                         ex: rec_data.exon_count};

    bagsel_ram #(
        .WIDTH (bagsel_pkg::REC_W),
        .DEPTH (MAX_GROUP)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (wr_rec),
        .re    (ram_re),
        .raddr (addr_reg[AW-1:0]),
        .rdata (rd_rec)
    );

    // Shared multiplier of the alpha test; its operands follow the step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctx_reg.step)
            3'd0:
            begin
                mul_a = 32'(ctx_reg.nmm);
                mul_b = 8'(ctx_reg.idi);
            end
            3'd1:
            begin
                mul_a = 32'(ctx_reg.nmi);
                mul_b = 8'(ctx_reg.idm);
            end
            3'd2:
            begin
                mul_a = 32'(ctx_reg.nmm - ctx_reg.nmi);
                mul_b = 8'(ctx_reg.idm);
            end
            3'd3:
            begin
                mul_a = ctx_reg.prod[31:0];
                mul_b = 8'(ctx_reg.idi);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = 40'(mul_a) * 40'(mul_b);
    assign d_ext    = {{8{ctx_reg.dval[32]}}, ctx_reg.dval};
    assign d80      = (d_ext << 6) + (d_ext << 4);
    assign alpha_lt = $signed({1'b0, ctx_reg.prod}) < $signed(d80);

    // When the margin exceeds the best match count, no record passes the margin test.
    assign mg_ok = (ctx_reg.q_nm >= 24'(margin_reg)) &&
                   (rd_rec.nm >= (ctx_reg.q_nm - 24'(margin_reg)));
    // A record with zero exons always passes; any other needs more than one exon beyond acc_ex.
    assign ex_ok = (rd_rec.ex == '0) || ((11'(ctx_reg.acc_ex) + 11'd1) < 11'(rd_rec.ex));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        vld_next       = 1'b0;
        ifi_id_next    = ifi_id_reg;
        ifi_nm_next    = ifi_nm_reg;
        mfi_id_next    = mfi_id_reg;
        mfi_nm_next    = mfi_nm_reg;
        ovf_next       = ovf_reg;
        margin_next    = cfg_we ? cfg_wdata : margin_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_data_next  = res_data_reg;
        ctx_next       = ctx_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (cnt_reg < CW'(MAX_GROUP))
                    begin
                        ram_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        if ((wr_rec.id > ifi_id_reg) ||
                            ((wr_rec.id == ifi_id_reg) && (wr_rec.nm > ifi_nm_reg)))
                        begin
                            ifi_id_next = wr_rec.id;
                            ifi_nm_next = wr_rec.nm;
                        end
                        if ((wr_rec.nm > mfi_nm_reg) ||
                            ((wr_rec.nm == mfi_nm_reg) && (wr_rec.id > mfi_id_reg)))
                        begin
                            mfi_id_next = wr_rec.id;
                            mfi_nm_next = wr_rec.nm;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (rec_data.last_in_group)
                    begin
                        addr_next        = '0;
                        ctx_next.sel_all = 1'b0;
                        ctx_next.acc_ex  = '0;
                        if (cnt_next == CW'(1))
                        begin
                            ctx_next.sel_all = 1'b1;
                            ctx_next.dcase   = bagsel_pkg::DC_SINGLE;
                            state_next       = S_EMIT_RD;
                        end
                        else if ((ifi_id_next == mfi_id_next) &&
                                 (ifi_nm_next == mfi_nm_next))
                        begin
                            ctx_next.q_id  = ifi_id_next;
                            ctx_next.q_nm  = ifi_nm_next;
                            ctx_next.phase = PH_EQ_MAX;
                            state_next     = S_SCAN;
                        end
                        else
                        begin
                            ctx_next.idi   = '0;
                            ctx_next.nmi   = '0;
                            ctx_next.idm   = '0;
                            ctx_next.nmm   = '0;
                            ctx_next.phase = PH_RANK;
                            state_next     = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                ram_re    = (addr_reg != cnt_reg);
                vld_next  = ram_re;
                addr_next = ram_re ? addr_reg + 1'b1 : addr_reg;
                if (vld_reg)
                begin
                    case (ctx_reg.phase) inside
                        PH_RANK:
                        begin
                            if (rd_rec.id > ctx_reg.idi)
                            begin
                                ctx_next.idm = ctx_reg.idi;
                                ctx_next.nmm = ctx_reg.nmi;
                                ctx_next.idi = rd_rec.id;
                                ctx_next.nmi = rd_rec.nm;
                            end
                            else if ((rd_rec.id == ctx_reg.idi) && (rd_rec.nm > ctx_reg.nmi))
                            begin
                                ctx_next.nmi = rd_rec.nm;
                            end
                            else if ((rd_rec.id < ctx_reg.idi) &&
                                     ((rd_rec.id > ctx_reg.idm) ||
                                      ((rd_rec.id == ctx_reg.idm) &&
                                       (rd_rec.nm > ctx_reg.nmm))))
                            begin
                                ctx_next.idm = rd_rec.id;
                                ctx_next.nmm = rd_rec.nm;
                            end
                        end
                        PH_EXX:
                        begin
                            if ((rd_rec.id == ctx_reg.idm) && (rd_rec.nm == ctx_reg.nmm) &&
                                (ctx_reg.exm < rd_rec.ex))
                            begin
                                ctx_next.exm = rd_rec.ex;
                            end
                            else if ((rd_rec.id == ctx_reg.idi) &&
                                     (rd_rec.nm == ctx_reg.nmi) &&
                                     (ctx_reg.exi < rd_rec.ex))
                            begin
                                ctx_next.exi = rd_rec.ex;
                            end
                        end
                        PH_EQ_MG, PH_R_MG, PH_M_MG:
                        begin
                            if ((rd_rec.id == ctx_reg.q_id) && mg_ok && ex_ok)
                            begin
                                ctx_next.acc_ex = rd_rec.ex;
                                ctx_next.acc_nm = rd_rec.nm;
                            end
                        end
                        default:
                        begin
                            if ((rd_rec.id == ctx_reg.q_id) && (rd_rec.nm >= ctx_reg.q_nm) &&
                                (ctx_reg.acc_ex < rd_rec.ex))
                            begin
                                ctx_next.acc_ex = rd_rec.ex;
                            end
                        end
                    endcase
                end
                else if (addr_reg == cnt_reg)
                begin
                    // Pass complete: pick the next pass, the alpha test or the verdict.
                    addr_next = '0;
                    case (ctx_reg.phase) inside
                        PH_EQ_MAX, PH_R_MAX:
                        begin
                            ctx_next.acc_nm = ctx_reg.q_nm;
                            ctx_next.phase  = (ctx_reg.phase == PH_EQ_MAX) ? PH_EQ_MG
                                                                          : PH_R_MG;
                        end
                        PH_EQ_MG, PH_R_MG:
                        begin
                            ctx_next.sid = ctx_reg.q_id;
                            ctx_next.snm = ctx_reg.acc_nm;
                            ctx_next.sex = ctx_reg.acc_ex;
                            if (ctx_reg.phase == PH_EQ_MG)
                            begin
                                ctx_next.dcase = (ctx_reg.acc_nm == ctx_reg.q_nm)
                                    ? bagsel_pkg::DC_AGREE_BEST : bagsel_pkg::DC_AGREE_EXONS;
                            end
                            else
                            begin
                                ctx_next.dcase = (ctx_reg.acc_nm == ctx_reg.q_nm)
                                    ? bagsel_pkg::DC_IDENT_BEST : bagsel_pkg::DC_IDENT_EXONS;
                            end
                            state_next = S_EMIT_RD;
                        end
                        PH_RANK:
                        begin
                            if (ctx_reg.nmi >= ctx_reg.nmm)
                            begin
                                ctx_next.q_id   = ctx_reg.idi;
                                ctx_next.q_nm   = ctx_reg.nmi;
                                ctx_next.acc_ex = '0;
                                ctx_next.phase  = PH_R_MAX;
                            end
                            else
                            begin
                                ctx_next.step = 3'd0;
                                state_next    = S_ALPHA;
                            end
                        end
                        PH_A_MAX:
                        begin
                            ctx_next.sid   = ctx_reg.idi;
                            ctx_next.snm   = ctx_reg.nmi;
                            ctx_next.sex   = ctx_reg.acc_ex;
                            ctx_next.dcase = bagsel_pkg::DC_ALPHA;
                            state_next     = S_EMIT_RD;
                        end
                        PH_EXX:
                        begin
                            if (((11'(ctx_reg.exm) + 11'd1) < 11'(ctx_reg.exi)) ||
                                ((8'(ctx_reg.idm) + bagsel_pkg::IDENT_SLACK) <
                                 8'(ctx_reg.idi)))
                            begin
                                ctx_next.sid   = ctx_reg.idi;
                                ctx_next.snm   = ctx_reg.nmi;
                                ctx_next.sex   = ctx_reg.exi;
                                ctx_next.dcase = ((11'(ctx_reg.exm) + 11'd1) <
                                                  11'(ctx_reg.exi))
                                    ? bagsel_pkg::DC_MORE_EXONS : bagsel_pkg::DC_IDENT_GAP;
                                state_next     = S_EMIT_RD;
                            end
                            else
                            begin
                                ctx_next.q_id   = ctx_reg.idm;
                                ctx_next.q_nm   = ctx_reg.nmm;
                                ctx_next.acc_ex = ctx_reg.exm;
                                ctx_next.acc_nm = ctx_reg.nmm;
                                ctx_next.phase  = PH_M_MG;
                            end
                        end
                        default:
                        begin
                            ctx_next.sid   = ctx_reg.idm;
                            ctx_next.snm   = ctx_reg.acc_nm;
                            ctx_next.sex   = ctx_reg.acc_ex;
                            ctx_next.dcase = (ctx_reg.acc_ex == ctx_reg.exm)
                                ? bagsel_pkg::DC_RUNNER_UP : bagsel_pkg::DC_RUNNER_EXONS;
                            state_next     = S_EMIT_RD;
                        end
                    endcase
                end
            end

            S_ALPHA:
            begin
                ctx_next.step = ctx_reg.step + 1'b1;
                case (ctx_reg.step)
                    3'd1:
                    begin
                        ctx_next.dval = 33'(ctx_reg.prod) - 33'(mul_p);
                    end
                    3'd4:
                    begin
                        addr_next = '0;
                        if ((ctx_reg.idm == '0) || alpha_lt)
                        begin
                            ctx_next.q_id   = ctx_reg.idi;
                            ctx_next.q_nm   = ctx_reg.nmi;
                            ctx_next.acc_ex = '0;
                            ctx_next.phase  = PH_A_MAX;
                        end
                        else
                        begin
                            ctx_next.exi   = '0;
                            ctx_next.exm   = '0;
                            ctx_next.phase = PH_EXX;
                        end
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        ctx_next.prod = mul_p;
                    end
                endcase
            end

            S_EMIT_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_EMIT_LD;
            end

            S_EMIT_LD:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next               = 1'b1;
                    res_data_next.record_index   = 6'(addr_reg);
                    res_data_next.selected       = ctx_reg.sel_all ||
                                                   ((rd_rec.id == ctx_reg.sid) &&
                                                    (rd_rec.nm == ctx_reg.snm) &&
                                                    (rd_rec.ex == ctx_reg.sex));
                    res_data_next.decision_case  = ctx_reg.dcase;
                    res_data_next.group_overflow = ovf_reg;
                    res_data_next.last_result    = ((addr_reg + 1'b1) == cnt_reg);
                    if ((addr_reg + 1'b1) == cnt_reg)
                    begin
                        cnt_next    = '0;
                        addr_next   = '0;
                        ifi_id_next = '0;
                        ifi_nm_next = '0;
                        mfi_id_next = '0;
                        mfi_nm_next = '0;
                        ovf_next    = 1'b0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        addr_next  = addr_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            vld_reg       <= 1'b0;
            ifi_id_reg    <= '0;
            ifi_nm_reg    <= '0;
            mfi_id_reg    <= '0;
            mfi_nm_reg    <= '0;
            ovf_reg       <= 1'b0;
            margin_reg    <= bagsel_pkg::MARGIN_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            addr_reg      <= addr_next;
            vld_reg       <= vld_next;
            ifi_id_reg    <= ifi_id_next;
            ifi_nm_reg    <= ifi_nm_next;
            mfi_id_reg    <= mfi_id_next;
            mfi_nm_reg    <= mfi_nm_next;
            ovf_reg       <= ovf_next;
            margin_reg    <= margin_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg      <= ctx_next;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // The store never holds more than MAX_GROUP records.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_GROUP))
        else $error("record count beyond capacity");

    // The store is only written while records are being loaded.
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE))
        else $error("store written during judging");

    // A shown result always carries one of the ten decision codes.
    a_case_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.decision_case <= bagsel_pkg::DC_RUNNER_EXONS))
        else $error("decision code out of range");

    // After the final result of a group is loaded, the group state is empty.
    a_group_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT_LD) && (state_next == S_IDLE)) |=>
        ((cnt_reg == '0) && !ovf_reg && res_data.last_result))
        else $error("group not cleared after its last result");

endmodule
